/* rtl/grid_selection_navigator_top_defines.svh */
// ----------------------------------------------------------------------------
// grid selection navigator assertion macros
// shared property forms for the checks inside the rtl modules
// ----------------------------------------------------------------------------
`ifndef GRID_SELECTION_NAVIGATOR_TOP_DEFINES_SVH
`define GRID_SELECTION_NAVIGATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GSN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define GSN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/gsn_pkg.sv */
// ----------------------------------------------------------------------------
// gsn_pkg
// types and constants shared by the grid selection navigator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsn_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int DIV_W     = 8;

    localparam logic signed [8:0] SEL_NONE = -9'sd1;

    // configuration register indexes
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_ITEM_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    typedef struct packed {
        logic load;       // latch button levels and clamped selection
        logic div_go;     // start the remainder unit
        logic div_sel_s;  // 0: divide n-1, 1: divide the selection
        logic cap_start;  // take start of last row from remainder
        logic cap_row;    // take row start and column from remainder
        logic step_en;    // apply one navigation rule
        dir_t dir;
        logic commit;     // write result and update state
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic sel_neg;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

/* rtl/gsn_rem.sv */
// ----------------------------------------------------------------------------
// gsn_rem
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsn_rem (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [gsn_pkg::DIV_W-1:0]    dividend,
    input  wire logic [gsn_pkg::DIV_W-1:0]    divisor,
    output logic                              done,
    output logic [gsn_pkg::DIV_W-1:0]         rem
);

    localparam int CW = $clog2(gsn_pkg::DIV_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CW-1:0]             cnt_reg;
    logic [gsn_pkg::DIV_W-1:0] dvd_reg;
    logic [gsn_pkg::DIV_W-1:0] dsr_reg;
    logic [gsn_pkg::DIV_W-1:0] pr_reg;
    logic [gsn_pkg::DIV_W:0]   trial;
    logic [gsn_pkg::DIV_W:0]   diff;

    assign trial = {pr_reg, dvd_reg[gsn_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(gsn_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            pr_reg  <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[gsn_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                pr_reg <= diff[gsn_pkg::DIV_W-1:0];
            end else begin
                pr_reg <= trial[gsn_pkg::DIV_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = pr_reg;

endmodule

`default_nettype wire

/* rtl/gsn_dp.sv */
// ----------------------------------------------------------------------------
// gsn_dp
// datapath: configuration, selection state, row tracking and the rule steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_selection_navigator_top_defines.svh"

module gsn_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gsn_pkg::cmd_t      cmd,
    output gsn_pkg::status_t        status,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_wdata,
    input  wire logic [3:0]         levels,
    output logic signed [8:0]       out_index,
    output logic                    out_changed
);

    logic [7:0]        col_reg;
    logic [8:0]        item_reg;
    logic signed [8:0] sel_reg;
    logic [3:0]        prev_reg;
    logic [3:0]        lv_reg;
    logic signed [8:0] s_reg;
    logic [7:0]        start_reg;
    logic [7:0]        rs_reg;
    logic [7:0]        rem_reg;
    logic              chg_reg;
    logic signed [8:0] out_idx_reg;
    logic              out_chg_reg;

    logic [8:0]        n_eff;
    logic [7:0]        c_eff;
    logic signed [8:0] nm1_s;
    logic [7:0]        nm1;
    logic [8:0]        cfg_n;
    logic signed [8:0] cfg_nm1_s;
    logic [3:0]        rise;
    logic [7:0]        s_u;
    logic              neg;

    logic              div_done;
    logic [7:0]        div_rem;
    logic [7:0]        div_dvd;

    logic [8:0]        t_up;
    logic [7:0]        up_clip;
    logic [8:0]        sum_dn;
    logic [8:0]        t_lf;
    logic [7:0]        lf_clip;

    logic signed [8:0] s_next;
    logic [7:0]        rs_next;
    logic [7:0]        rem_next;
    logic              act;
    logic              hit;

    assign n_eff = (item_reg > 9'(gsn_pkg::MAX_ITEMS)) ? 9'(gsn_pkg::MAX_ITEMS) : item_reg;
    assign c_eff = (col_reg == 8'd0) ? 8'd1 : col_reg;
    assign nm1_s = $signed(n_eff - 9'd1);
    assign nm1   = nm1_s[7:0];

    assign cfg_n = (cfg_wdata > 9'(gsn_pkg::MAX_ITEMS)) ? 9'(gsn_pkg::MAX_ITEMS) : cfg_wdata;
    assign cfg_nm1_s = $signed(cfg_n - 9'd1);

    assign rise = lv_reg & ~prev_reg;
    assign s_u  = s_reg[7:0];
    assign neg  = s_reg[8];

    assign div_dvd = cmd.div_sel_s ? s_u : nm1;

    gsn_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (div_dvd),
        .divisor  (c_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    // candidate cells for the wrap cases
    assign t_up    = {1'b0, start_reg} + {1'b0, rem_reg};
    assign up_clip = (t_up > {1'b0, nm1}) ? nm1 : t_up[7:0];
    assign sum_dn  = {1'b0, s_u} + {1'b0, c_eff};
    assign t_lf    = {1'b0, rs_reg} + {1'b0, c_eff} - 9'd1;
    assign lf_clip = (t_lf > {1'b0, nm1}) ? nm1 : t_lf[7:0];

    always_comb begin
        s_next   = s_reg;
        rs_next  = rs_reg;
        rem_next = rem_reg;
        act      = 1'b0;
        hit      = 1'b1;
        case (cmd.dir)
            gsn_pkg::DIR_UP: begin
                act = rise[0];
                if (!neg && rs_reg != 8'd0) begin
                    s_next  = s_reg - $signed({1'b0, c_eff});
                    rs_next = rs_reg - c_eff;
                end else if (neg) begin
                    s_next   = $signed({1'b0, nm1});
                    rs_next  = start_reg;
                    rem_next = nm1 - start_reg;
                end else begin
                    s_next   = $signed({1'b0, up_clip});
                    rs_next  = start_reg;
                    rem_next = up_clip - start_reg;
                end
            end
            gsn_pkg::DIR_DOWN: begin
                act = rise[1];
                if (neg) begin
                    s_next   = 9'sd0;
                    rs_next  = 8'd0;
                    rem_next = 8'd0;
                end else if (rs_reg < start_reg) begin
                    // blocked when the cell below is past the last item
                    if (sum_dn < n_eff) begin
                        s_next  = $signed(sum_dn);
                        rs_next = rs_reg + c_eff;
                    end else begin
                        hit = 1'b0;
                    end
                end else begin
                    s_next  = $signed({1'b0, rem_reg});
                    rs_next = 8'd0;
                end
            end
            gsn_pkg::DIR_LEFT: begin
                act = rise[2];
                if (!neg && s_u != 8'd0 && rem_reg != 8'd0) begin
                    s_next   = s_reg - 9'sd1;
                    rem_next = rem_reg - 8'd1;
                end else if (neg) begin
                    s_next   = $signed({1'b0, nm1});
                    rs_next  = start_reg;
                    rem_next = nm1 - start_reg;
                end else begin
                    s_next   = $signed({1'b0, lf_clip});
                    rem_next = lf_clip - rs_reg;
                end
            end
            gsn_pkg::DIR_RIGHT: begin
                act = rise[3];
                if (!neg && s_u < nm1 && rem_reg != c_eff - 8'd1) begin
                    s_next   = s_reg + 9'sd1;
                    rem_next = rem_reg + 8'd1;
                end else if (neg) begin
                    s_next   = 9'sd0;
                    rs_next  = 8'd0;
                    rem_next = 8'd0;
                end else begin
                    s_next   = $signed({1'b0, rs_reg});
                    rem_next = 8'd0;
                end
            end
            default: begin
                act = 1'b0;
            end
        endcase
    end

    // configuration and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= 8'd1;
            item_reg <= 9'd0;
            sel_reg  <= gsn_pkg::SEL_NONE;
            prev_reg <= 4'd0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == gsn_pkg::REG_COLUMN_COUNT) begin
                    col_reg <= cfg_wdata[7:0];
                end else begin
                    item_reg <= cfg_wdata;
                    if (sel_reg > cfg_nm1_s) begin
                        sel_reg <= cfg_nm1_s;
                    end
                end
            end else if (cmd.commit) begin
                if (n_eff == 9'd0) begin
                    sel_reg <= gsn_pkg::SEL_NONE;
                end else begin
                    sel_reg  <= s_reg;
                    prev_reg <= lv_reg;
                end
            end
        end
    end

    // working registers for the item in flight
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lv_reg  <= levels;
            s_reg   <= (sel_reg > nm1_s) ? nm1_s : sel_reg;
            chg_reg <= 1'b0;
        end
        if (cmd.cap_start) begin
            start_reg <= nm1 - div_rem;
        end
        if (cmd.cap_row) begin
            rs_reg  <= s_u - div_rem;
            rem_reg <= div_rem;
        end
        if (cmd.step_en && act) begin
            s_reg   <= s_next;
            rs_reg  <= rs_next;
            rem_reg <= rem_next;
            chg_reg <= chg_reg | hit;
        end
        if (cmd.commit) begin
            if (n_eff == 9'd0) begin
                out_idx_reg <= gsn_pkg::SEL_NONE;
                out_chg_reg <= 1'b0;
            end else begin
                out_idx_reg <= s_reg;
                out_chg_reg <= chg_reg;
            end
        end
    end

    assign status.empty    = (n_eff == 9'd0);
    assign status.sel_neg  = neg;
    assign status.div_done = div_done;

    assign out_index   = out_idx_reg;
    assign out_changed = out_chg_reg;

    `GSN_ASSERT_IMP(a_sel_in_range, aclk, aresetn, 1'b1, sel_reg <= nm1_s)
    `GSN_ASSERT_IMP(a_rem_below_cols, aclk, aresetn, div_done, div_rem < c_eff)

endmodule

`default_nettype wire

/* rtl/gsn_ctrl.sv */
// ----------------------------------------------------------------------------
// gsn_ctrl
// sequencer: up to two remainder passes, four rule steps, then the result commit; an empty grid skips to the commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_selection_navigator_top_defines.svh"

module gsn_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire gsn_pkg::status_t    status,
    output gsn_pkg::cmd_t            cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_N_GO,
        ST_DIV_N_WAIT,
        ST_DIV_S_GO,
        ST_DIV_S_WAIT,
        ST_UP,
        ST_DOWN,
        ST_LEFT,
        ST_RIGHT,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.dir      = gsn_pkg::DIR_UP;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.empty ? ST_COMMIT : ST_DIV_N_GO;
                end
            end
            ST_DIV_N_GO: begin
                cmd.div_go = 1'b1;
                state_next = ST_DIV_N_WAIT;
            end
            ST_DIV_N_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_start = 1'b1;
                    // nothing selected: no row to look up
                    state_next = status.sel_neg ? ST_UP : ST_DIV_S_GO;
                end
            end
            ST_DIV_S_GO: begin
                cmd.div_go    = 1'b1;
                cmd.div_sel_s = 1'b1;
                state_next    = ST_DIV_S_WAIT;
            end
            ST_DIV_S_WAIT: begin
                cmd.div_sel_s = 1'b1;
                if (status.div_done) begin
                    cmd.cap_row = 1'b1;
                    state_next  = ST_UP;
                end
            end
            ST_UP: begin
                cmd.step_en = 1'b1;
                cmd.dir     = gsn_pkg::DIR_UP;
                state_next  = ST_DOWN;
            end
            ST_DOWN: begin
                cmd.step_en = 1'b1;
                cmd.dir     = gsn_pkg::DIR_DOWN;
                state_next  = ST_LEFT;
            end
            ST_LEFT: begin
                cmd.step_en = 1'b1;
                cmd.dir     = gsn_pkg::DIR_LEFT;
                state_next  = ST_RIGHT;
            end
            ST_RIGHT: begin
                cmd.step_en = 1'b1;
                cmd.dir     = gsn_pkg::DIR_RIGHT;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (slot_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `GSN_ASSERT_IMP(a_commit_slot_free, aclk, aresetn, cmd.commit, slot_free)
    `GSN_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `GSN_ASSERT_NXT(a_commit_shows_result, aclk, aresetn, cmd.commit, m_valid)

endmodule

`default_nettype wire

/* rtl/grid_selection_navigator_top.sv */
// ----------------------------------------------------------------------------
// grid_selection_navigator_top
// menu cursor on a row-major grid driven by four navigation buttons
// ----------------------------------------------------------------------------
// Each input transfer carries the up, down, left and right button levels of
// one tick; each gives exactly one result transfer with the selected index
// (-1 for none) and a flag telling whether a rule acted. Rising edges are
// applied up, down, left, right in turn, each with its wrap rule. An item
// is accepted only while the sequencer is idle, so the next input waits until
// the previous item has committed. After the accepting cycle the shared
// bit-serial remainder unit finds the last row of the grid and then the row
// of the selection (skipped when nothing is selected), each navigation rule
// takes its own step and the result is committed; an empty grid goes
// straight from the accepting cycle to the commit. The result waits in an
// output register, so a stalled result holds up the next item only at its
// commit. Configuration is written with cfg_wr_en: index 0 is the column
// count (zero acts as one), index 1 is the item count (saturated at 256;
// lowering it clamps the selection).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_selection_navigator_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_up_level,
    input  wire logic               s_down_level,
    input  wire logic               s_left_level,
    input  wire logic               s_right_level,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [8:0]       m_selected_index,
    output logic                    m_selection_changed,

    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_wdata
);

    gsn_pkg::cmd_t    cmd;
    gsn_pkg::status_t status;
    logic [3:0]       levels;

    assign levels = {s_right_level, s_left_level, s_down_level, s_up_level};

    gsn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gsn_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .levels      (levels),
        .out_index   (m_selected_index),
        .out_changed (m_selection_changed)
    );

endmodule

`default_nettype wire
